FILE: rtl/core/knc_pkg.sv
// ----------------------------------------------------------------------------
// knc_pkg
// Shared types and constants for the knapsack cipher engine.
// ----------------------------------------------------------------------------
package knc_pkg;

	localparam int WORD_W = 31;
	localparam int MSG_W  = 16;
	localparam int IDX_W  = 4;
	localparam int STEP_W = 5;

	// input func codes
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
	localparam logic [1:0] FUNC_DECRYPT = 2'd2;

	// configuration register indexes
	localparam logic REG_MODULUS    = 1'b0;
	localparam logic REG_MULTIPLIER = 1'b1;

	// arithmetic unit operations
	localparam logic OP_DIV = 1'b0;
	localparam logic OP_MUL = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
	} arith_req_t;

endpackage

FILE: rtl/core/knapsack_cipher_engine.sv
// ----------------------------------------------------------------------------
// knapsack_cipher_engine
// Merkle-Hellman knapsack engine: key load, encrypt and decrypt.
// ----------------------------------------------------------------------------
// A load word (func 0) writes one private key entry and gives no result;
// func 3 is dropped. Encrypt and decrypt each return one result word.
// Divides and multiplies run through a single bit-serial unit doing either
// a 31-step restoring divide or a modular multiply by double-and-add.
// Encrypt reduces w, then per set message bit reduces the key entry,
// multiplies it by w and adds mod m. Decrypt reduces w and c, then runs
// extended Euclid rounds (a divide plus a modular multiply of the
// coefficient), then multiplies c by the inverse and does a greedy walk
// over the key entries. One word is in flight at a time; s_axis_tready
// is high only when idle. The result sits in an output register, so the
// next word may be taken while it waits. Modulus below two is used as two.
// Status 1 means w has no inverse mod m. Configuration must be written
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module knapsack_cipher_engine #(
	parameter int KEY_LENGTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,   // 0 modulus, 1 multiplier
	input  logic [30:0] cfg_data,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // key_index[3:0], key_value[34:4],
	                                    // message_bits[50:35], cipher_in[81:51]
	input  logic [1:0]  s_axis_tuser,  // func
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // cipher_out[30:0], plain_bits[46:31],
	                                    // status[47]
);
	import knc_pkg::*;

	localparam int KI_W  = $clog2(KEY_LENGTH);
	localparam int EN_N  = (KEY_LENGTH < MSG_W) ? KEY_LENGTH : MSG_W;

	localparam logic [4:0] S_IDLE = 5'd0,  S_WISS = 5'd1,  S_WWAIT = 5'd2,
	                       S_ECHK = 5'd3,  S_ERD  = 5'd4,  S_EKW   = 5'd5,
	                       S_EMI  = 5'd6,  S_EMW  = 5'd7,  S_DCI   = 5'd8,
	                       S_DCW  = 5'd9,  S_GCHK = 5'd10, S_GDW   = 5'd11,
	                       S_GMI  = 5'd12, S_GMW  = 5'd13, S_DMI   = 5'd14,
	                       S_DMW  = 5'd15, S_WRD  = 5'd16, S_WCMP  = 5'd17,
	                       S_FIN  = 5'd18;

	logic [4:0]        state_q;
	logic [WORD_W-1:0] modulus_q, multiplier_q, m_eff;
	logic [1:0]        func_q;
	logic [MSG_W-1:0]  msg_q, plain_q;
	logic [WORD_W-1:0] cin_q, w_q, kmod_q, sum_q, c_q;
	logic [WORD_W-1:0] r0_q, r1_q, t0_q, t1_q, q_q, nr_q;
	logic              fail_q;
	logic [KI_W-1:0]   idx_q;
	logic [KEY_LENGTH-1:0] vld_q;
	logic              key_vld_q;
	logic [WORD_W-1:0] ram_rdata, key_rd;
	logic              out_valid_q;
	logic [47:0]       out_data_q;

	logic              in_acc, load_ok, fin_load;
	logic [3:0]        in_kidx;
	arith_req_t        req;
	logic [WORD_W-1:0] opa, opb, dvsr, ar_res, ar_quo;
	logic              ar_done;
	logic [WORD_W:0]   add_s, sub_s;

	assign m_eff     = (modulus_q < WORD_W'(2)) ? WORD_W'(2) : modulus_q;
	assign cfg_ready = 1'b1;
	assign s_axis_tready = state_q == S_IDLE;
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_kidx   = s_axis_tdata[3:0];
	assign load_ok   = in_acc && s_axis_tuser == FUNC_LOAD
	                   && {3'b0, in_kidx} < 7'(KEY_LENGTH);
	assign key_rd    = key_vld_q ? ram_rdata : '0;
	// result register takes a new word when empty or being drained
	assign fin_load  = state_q == S_FIN && (!out_valid_q || m_axis_tready);

	knc_ram #(.WIDTH(WORD_W), .DEPTH(KEY_LENGTH)) u_key_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (KI_W'(in_kidx)),
		.wdata (s_axis_tdata[34:4]),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// operand select for the shared unit
	always_comb begin
		req  = '{start: 1'b0, op: OP_DIV};
		opa  = '0;
		opb  = '0;
		dvsr = m_eff;
		case (state_q)
			S_WISS: begin
				req.start = 1'b1; opa = multiplier_q;
			end
			S_ERD: begin
				req.start = 1'b1; opa = key_rd;
			end
			S_EMI: begin
				req = '{start: 1'b1, op: OP_MUL}; opa = kmod_q; opb = w_q;
			end
			S_DCI: begin
				req.start = 1'b1; opa = cin_q;
			end
			S_GCHK: begin
				req.start = r1_q != '0; opa = r0_q; dvsr = r1_q;
			end
			S_GMI: begin
				req = '{start: 1'b1, op: OP_MUL}; opa = t1_q; opb = q_q;
			end
			S_DMI: begin
				req = '{start: 1'b1, op: OP_MUL}; opa = c_q; opb = t0_q;
			end
			default: ;
		endcase
	end

	knc_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.dvsr   (dvsr),
		.done   (ar_done),
		.res    (ar_res),
		.quo    (ar_quo)
	);

	assign add_s = {1'b0, sum_q} + {1'b0, ar_res};
	// (t0 - p) mod m
	assign sub_s = (t0_q >= ar_res) ? {1'b0, t0_q} - {1'b0, ar_res}
	                                : {1'b0, t0_q} + {1'b0, m_eff} - {1'b0, ar_res};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			modulus_q    <= 31'h7FFF_FFFF;
			multiplier_q <= 31'd1;
			vld_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODULUS) modulus_q <= cfg_data;
				else                          multiplier_q <= cfg_data;
			end
			if (load_ok) vld_q[KI_W'(in_kidx)] <= 1'b1;
			if (fin_load)           out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:
					if (in_acc && (s_axis_tuser == FUNC_ENCRYPT
					               || s_axis_tuser == FUNC_DECRYPT)) begin
						state_q <= S_WISS;
					end
				S_WISS:  state_q <= S_WWAIT;
				S_WWAIT:
					if (ar_done) state_q <= (func_q == FUNC_ENCRYPT) ? S_ECHK : S_DCI;
				S_ECHK:
					if (msg_q[0]) state_q <= S_ERD;
					else if (idx_q == KI_W'(EN_N - 1)) state_q <= S_FIN;
				S_ERD:   state_q <= S_EKW;
				S_EKW:   if (ar_done) state_q <= S_EMI;
				S_EMI:   state_q <= S_EMW;
				S_EMW:
					if (ar_done) state_q <= (idx_q == KI_W'(EN_N - 1)) ? S_FIN : S_ECHK;
				S_DCI:   state_q <= S_DCW;
				S_DCW:   if (ar_done) state_q <= S_GCHK;
				S_GCHK:
					if (r1_q != '0)       state_q <= S_GDW;
					else if (r0_q != WORD_W'(1)) state_q <= S_FIN;
					else                  state_q <= S_DMI;
				S_GDW:   if (ar_done) state_q <= S_GMI;
				S_GMI:   state_q <= S_GMW;
				S_GMW:   if (ar_done) state_q <= S_GCHK;
				S_DMI:   state_q <= S_DMW;
				S_DMW:   if (ar_done) state_q <= S_WRD;
				S_WRD:   state_q <= S_WCMP;
				S_WCMP:  state_q <= (idx_q == '0) ? S_FIN : S_WRD;
				S_FIN:
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		key_vld_q <= vld_q[idx_q];
		case (state_q)
			S_IDLE:
				if (in_acc) begin
					func_q  <= s_axis_tuser;
					msg_q   <= s_axis_tdata[50:35];
					cin_q   <= s_axis_tdata[81:51];
					sum_q   <= '0;
					plain_q <= '0;
					fail_q  <= 1'b0;
					idx_q   <= '0;
				end
			S_WWAIT: if (ar_done) w_q <= ar_res;
			S_ECHK:
				if (!msg_q[0]) begin
					idx_q <= idx_q + 1'b1;
					msg_q <= msg_q >> 1;
				end
			S_EKW: if (ar_done) kmod_q <= ar_res;
			S_EMW:
				if (ar_done) begin
					sum_q <= (add_s >= {1'b0, m_eff}) ? WORD_W'(add_s - {1'b0, m_eff})
					                                  : add_s[WORD_W-1:0];
					idx_q <= idx_q + 1'b1;
					msg_q <= msg_q >> 1;
				end
			S_DCW:
				if (ar_done) begin
					c_q  <= ar_res;
					r0_q <= m_eff;
					r1_q <= w_q;
					t0_q <= '0;
					t1_q <= WORD_W'(1);
				end
			S_GCHK:
				if (r1_q == '0 && r0_q != WORD_W'(1)) fail_q <= 1'b1;
			S_GDW:
				if (ar_done) begin
					q_q  <= ar_quo;
					nr_q <= ar_res;
				end
			S_GMW:
				if (ar_done) begin
					r0_q <= r1_q;
					r1_q <= nr_q;
					t0_q <= t1_q;
					t1_q <= sub_s[WORD_W-1:0];
				end
			S_DMW:
				if (ar_done) begin
					sum_q <= ar_res;  // walk remainder
					idx_q <= KI_W'(KEY_LENGTH - 1);
				end
			S_WCMP: begin
				if (key_rd <= sum_q) sum_q <= sum_q - key_rd;
				plain_q <= {plain_q[MSG_W-2:0], key_rd <= sum_q};
				idx_q   <= idx_q - 1'b1;
			end
			S_FIN:
				if (fin_load) begin
					out_data_q <= {fail_q,
					               (func_q == FUNC_DECRYPT && !fail_q) ? plain_q : '0,
					               (func_q == FUNC_ENCRYPT) ? sum_q : '0};
				end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[47]) |-> m_axis_tdata[46:0] == '0)
		else $error("failed decrypt carries data");
	a_walk_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WCMP |=> (state_q == S_WRD || state_q == S_FIN))
		else $error("walk sequencing broken");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !m_axis_tready) |=> state_q == S_FIN)
		else $error("result overwritten before taken");
endmodule

FILE: rtl/core/knc_ram.sv
// ----------------------------------------------------------------------------
// knc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module knc_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/knc_arith.sv
// ----------------------------------------------------------------------------
// knc_arith
// Shared bit-serial unit: restoring divide (quotient, remainder) or
// modular multiply by double-and-add. Two adders and one compare-subtract.
// ----------------------------------------------------------------------------
module knc_arith (
	input  logic                      clk,
	input  logic                      arst_n,
	input  knc_pkg::arith_req_t       req,
	input  logic [knc_pkg::WORD_W-1:0] opa,   // dividend / multiplicand (< dvsr)
	input  logic [knc_pkg::WORD_W-1:0] opb,   // multiplier bits
	input  logic [knc_pkg::WORD_W-1:0] dvsr,  // divisor / modulus
	output logic                      done,
	output logic [knc_pkg::WORD_W-1:0] res,   // remainder or product mod dvsr
	output logic [knc_pkg::WORD_W-1:0] quo
);
	import knc_pkg::*;

	logic              busy_q, done_q, op_q, phase_q;
	logic [STEP_W-1:0] cnt_q;
	logic [WORD_W-1:0] x_q, d_q, a_q, acc_q, quo_q;
	logic [WORD_W:0]   addend, sum, diff;
	logic              ge, last;

	// DIV: 2*acc + next bit; MUL phase 0: 2*acc; phase 1: acc + a if bit set
	always_comb begin
		if (op_q == OP_DIV || !phase_q) begin
			addend = {1'b0, acc_q} + {{WORD_W{1'b0}}, (op_q == OP_DIV) & x_q[WORD_W-1]};
		end else begin
			addend = x_q[WORD_W-1] ? {1'b0, a_q} : '0;
		end
		sum  = {1'b0, acc_q} + addend;
		ge   = sum >= {1'b0, d_q};
		diff = sum - {1'b0, d_q};
		last = cnt_q == STEP_W'(WORD_W - 1) && (op_q == OP_DIV || phase_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					phase_q <= !phase_q;
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (op_q == OP_DIV || phase_q) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			x_q   <= (req.op == OP_DIV) ? opa : opb;
			a_q   <= opa;
			d_q   <= dvsr;
			acc_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			acc_q <= ge ? diff[WORD_W-1:0] : sum[WORD_W-1:0];
			if (op_q == OP_DIV) begin
				quo_q <= {quo_q[WORD_W-2:0], ge};
			end
			if (op_q == OP_DIV || phase_q) begin
				x_q <= {x_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
	assign quo  = quo_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("arith done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("arith started while busy");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && d_q != '0) |-> acc_q < d_q) else $error("arith residue out of range");
endmodule

FILE: tb/sv/knapsack_cipher_engine_tb.sv
// ----------------------------------------------------------------------------
// knapsack_cipher_engine_tb
// Self-checking bench: key loads, encrypt and decrypt words against a local
// knapsack predictor, with random bursts, receiver stalls and config phases.
// ----------------------------------------------------------------------------
module knapsack_cipher_engine_tb;
	import knc_pkg::*;

	// func code that the engine drops
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int KEYS         = 16;
	localparam int IDLE_LIMIT   = 40000;   // cycles with no handshake at all
	localparam int HOLD_CYCLES  = 3000;    // long receiver hold-off
	localparam int SETTLE       = 40;      // latency allowance after last result

	typedef struct {
		logic [30:0] cipher;
		logic [15:0] plain;
		logic        status;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [30:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;   // key_index, key_value, message_bits, cipher_in
	logic [1:0]  s_axis_tuser;   // func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // cipher_out, plain_bits, status

	knapsack_cipher_engine #(.KEY_LENGTH(KEYS)) dut (.*);

	// predictor copy of the engine state
	logic [30:0] mod_reg;
	logic [30:0] mult_reg;
	logic [30:0] key_mem [KEYS];

	result_t expected_q [$];
	int      err_cnt;
	int      burst_left;
	int      idle_cnt;
	bit      hold_req;
	int      hold_left;
	bit      stall_mode;
	int      mode_left;

	always #6 clk = ~clk;

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	function automatic longint unsigned eff_mod();
		return (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
	endfunction

	// extended Euclid; returns 1 and the inverse when w is a unit mod m
	function automatic bit inverse_of(input longint unsigned w, input longint unsigned m,
			output longint unsigned inv);
		longint r0, r1, t0, t1, q, nr, nt;
		r0 = m;
		r1 = w % m;
		t0 = 0;
		t1 = 1;
		inv = 0;
		while (r1 != 0) begin
			q  = r0 / r1;
			nr = r0 - q * r1;
			nt = t0 - q * t1;
			r0 = r1; r1 = nr;
			t0 = t1; t1 = nt;
		end
		if (r0 != 1)
			return 1'b0;
		if (t0 < 0)
			t0 += m;
		inv = longint'(t0) % m;
		return 1'b1;
	endfunction

	function automatic logic [30:0] knapsack_sum(input logic [15:0] msg);
		longint unsigned m, w, s;
		m = eff_mod();
		w = mult_reg % m;
		s = 0;
		for (int i = 0; i < KEYS; i++)
			if (msg[i])
				s = (s + (w * (key_mem[i] % m)) % m) % m;
		return s[30:0];
	endfunction

	function automatic result_t greedy_decrypt(input logic [30:0] c);
		result_t r;
		longint unsigned m, inv, s;
		m = eff_mod();
		r.cipher = '0;
		r.plain  = '0;
		r.status = 1'b0;
		if (!inverse_of(mult_reg % m, m, inv)) begin
			r.status = 1'b1;
			return r;
		end
		s = ((c % m) * inv) % m;
		for (int i = KEYS - 1; i >= 0; i--)
			if (key_mem[i] <= s) begin
				s -= key_mem[i];
				r.plain[i] = 1'b1;
			end
		return r;
	endfunction

	// one input word; prediction is taken at the accepting edge, in send order
	task automatic send_word(input logic [1:0] fn, input logic [3:0] idx,
			input logic [30:0] kval, input logic [15:0] msg, input logic [30:0] cin);
		result_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fn;
		s_axis_tdata  <= {6'd0, cin, msg, kval, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		case (fn)
			FUNC_LOAD: begin
				key_mem[idx] = kval;
			end
			FUNC_ENCRYPT: begin
				r.cipher = knapsack_sum(msg);
				r.plain  = '0;
				r.status = 1'b0;
				expected_q.push_back(r);
			end
			FUNC_DECRYPT: begin
				expected_q.push_back(greedy_decrypt(cin));
			end
			default: ;
		endcase
	endtask

	// stop offering and wait until every result is back, then let it settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [30:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_MODULUS)
			mod_reg = val;
		else
			mult_reg = val;
	endtask

	task automatic encrypt(input logic [15:0] msg);
		send_word(FUNC_ENCRYPT, 4'($urandom), 31'($urandom), msg, 31'($urandom));
	endtask

	task automatic decrypt(input logic [30:0] c);
		send_word(FUNC_DECRYPT, 4'($urandom), 31'($urandom), 16'($urandom), c);
	endtask

	task automatic load_key(input logic [3:0] idx, input logic [30:0] val);
		send_word(FUNC_LOAD, idx, val, 16'($urandom), 31'($urandom));
	endtask

	// superincreasing key, modulus above its sum and a multiplier coprime to it
	task automatic new_keyset(input int step_max);
		longint unsigned total, m, w, inv;
		logic [30:0] k;
		total = 0;
		for (int i = 0; i < KEYS; i++) begin
			k = 31'(total + $urandom_range(1, step_max));
			load_key(4'(i), k);
			total += k;
		end
		m = total + 1 + $urandom_range(0, step_max);
		if (m > 64'h7FFF_FFFF)
			m = 64'h7FFF_FFFF;
		do
			w = $urandom_range(1, int'(m - 1));
		while (!inverse_of(w, m, inv));
		write_reg(REG_MODULUS, m[30:0]);
		write_reg(REG_MULTIPLIER, w[30:0]);
	endtask

	// corner words at reset settings and at the register extremes
	task automatic test_directed();
		encrypt(16'hFFFF);                      // all-zero key table
		load_key(4'd15, 31'h7FFF_FFFF);         // key equal to modulus
		load_key(4'd0, 31'd0);
		load_key(4'd3, 31'd12345);
		send_word(FUNC_UNUSED, 4'd3, 31'd1, 16'hFFFF, 31'd5);  // dropped
		encrypt(16'hFFFF);
		encrypt(16'h0000);
		decrypt(31'h7FFF_FFFE);
		decrypt(31'h7FFF_FFFF);                 // cipher at modulus
		decrypt(31'd0);
		write_reg(REG_MODULUS, 31'd0);          // used as two
		encrypt(16'h8009);
		decrypt(31'd1);
		write_reg(REG_MODULUS, 31'd1);
		decrypt(31'd3);
		write_reg(REG_MODULUS, 31'd97);
		write_reg(REG_MULTIPLIER, 31'd0);       // no inverse
		decrypt(31'd50);
		encrypt(16'h0008);
		write_reg(REG_MULTIPLIER, 31'h7FFF_FFFE); // reduced mod m
		encrypt(16'hFFFF);
		decrypt(31'd96);
		write_reg(REG_MODULUS, 31'd100);
		write_reg(REG_MULTIPLIER, 31'd10);      // shares a factor with m
		decrypt(31'd42);
		write_reg(REG_MODULUS, 31'h7FFF_FFFF);
		write_reg(REG_MULTIPLIER, 31'h7FFF_FFFE);
		encrypt(16'hFFFF);
		decrypt(31'h7FFF_FFFE);
	endtask

	// encrypt/decrypt pairs on fresh key sets, with a little noise
	task automatic test_roundtrip(input int step_max, input int pairs);
		logic [15:0] msg;
		new_keyset(step_max);
		for (int n = 0; n < pairs; n++) begin
			case ($urandom_range(0, 9))
				0: decrypt(31'($urandom));
				1: send_word(FUNC_UNUSED, 4'($urandom), 31'($urandom), 16'($urandom),
						31'($urandom));
				default: begin
					msg = 16'($urandom);
					encrypt(msg);
					decrypt(knapsack_sum(msg));
				end
			endcase
		end
		// broken key: random entry overwritten, then a few more words
		load_key(4'($urandom), 31'($urandom));
		encrypt(16'($urandom));
		decrypt(31'($urandom));
	endtask

	// receiver holds off long while words keep coming, then a full pause
	task automatic test_backpressure();
		logic [15:0] msg;
		hold_req = 1'b1;
		for (int n = 0; n < 8; n++) begin
			msg = 16'($urandom);
			encrypt(msg);
			decrypt(knapsack_sum(msg));
		end
		drain();
		for (int n = 0; n < 6; n++)
			encrypt(16'($urandom));
	endtask

	// receiver: stretches of random stalls, stretches of none, one hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left  = 0;
			mode_left  = 0;
			stall_mode = 1'b0;
		end else begin
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode_left  = $urandom_range(20, 300);
				stall_mode = $urandom_range(0, 1);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
			end
		end
	end

	// result checker: oldest expectation against each accepted word
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				report("unexpected word", m_axis_tdata, 0);
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata[30:0] !== want.cipher)
					report("cipher_out", m_axis_tdata[30:0], want.cipher);
				if (m_axis_tdata[46:31] !== want.plain)
					report("plain_bits", m_axis_tdata[46:31], want.plain);
				if (m_axis_tdata[47] !== want.status)
					report("status", m_axis_tdata[47], want.status);
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		err_cnt       = 0;
		burst_left    = 0;
		idle_cnt      = 0;
		hold_req      = 1'b0;
		mod_reg       = 31'h7FFF_FFFF;
		mult_reg      = 31'd1;
		foreach (key_mem[i])
			key_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_roundtrip(8, 25);            // small modulus
		test_backpressure();
		test_roundtrip(2000, 30);
		test_roundtrip(30000, 30);        // modulus near full width
		test_roundtrip(300, 30);

		drain();
		if (err_cnt == 0 && expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/knc_pkg.sv
rtl/core/knc_ram.sv
rtl/core/knc_arith.sv
rtl/core/knapsack_cipher_engine.sv
tb/sv/knapsack_cipher_engine_tb.sv
